// File: hw/rtl/timed_ramp_hold_profile_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timed ramp and hold profile block
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TIMED_RAMP_HOLD_PROFILE_ASSERT_SVH
`define TIMED_RAMP_HOLD_PROFILE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TRHP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TRHP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/trhp_pkg.sv
// ----------------------------------------------------------------------------
// trhp_pkg
// Types and constants shared by the timed ramp and hold profile modules.
// ----------------------------------------------------------------------------
package trhp_pkg;

  typedef enum logic [3:0] {
    PH_UP      = 4'b0001,
    PH_HOLD_HI = 4'b0010,
    PH_DOWN    = 4'b0100,
    PH_HOLD_LO = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    CFG_MAX_POS   = 3'd0,
    CFG_UP_STEP   = 3'd1,
    CFG_DOWN_STEP = 3'd2,
    CFG_UP_TIME   = 3'd3,
    CFG_HI_TIME   = 3'd4,
    CFG_DOWN_TIME = 3'd5,
    CFG_LO_TIME   = 3'd6
  } cfg_idx_e;

  localparam logic [1:0] PCODE_UP      = 2'd0;
  localparam logic [1:0] PCODE_HOLD_HI = 2'd1;
  localparam logic [1:0] PCODE_DOWN    = 2'd2;
  localparam logic [1:0] PCODE_HOLD_LO = 2'd3;

  localparam int unsigned POS_W     = 10;
  localparam int unsigned STEP_W    = 20;
  localparam int unsigned TIME_W    = 16;
  localparam int unsigned DELTA_W   = 8;
  localparam int unsigned PANEL_W   = 16;
  localparam int unsigned GOAL_W    = 26;
  localparam int unsigned CFG_W     = 20;
  localparam int unsigned START_BIT = 4;

  localparam logic [POS_W-1:0]  MAX_POS_RST   = 10'd900;
  localparam logic [STEP_W-1:0] UP_STEP_RST   = 20'd2949;
  localparam logic [STEP_W-1:0] DOWN_STEP_RST = 20'd2949;
  localparam logic [TIME_W-1:0] UP_TIME_RST   = 16'd20000;
  localparam logic [TIME_W-1:0] HI_TIME_RST   = 16'd20000;
  localparam logic [TIME_W-1:0] DOWN_TIME_RST = 16'd20000;
  localparam logic [TIME_W-1:0] LO_TIME_RST   = 16'd24000;

  typedef struct packed {
    logic [POS_W-1:0]  max_pos;
    logic [STEP_W-1:0] up_step;
    logic [STEP_W-1:0] down_step;
    logic [TIME_W-1:0] up_time;
    logic [TIME_W-1:0] hi_time;
    logic [TIME_W-1:0] down_time;
    logic [TIME_W-1:0] lo_time;
  } cfg_t;

  typedef struct packed {
    phase_e            phase;
    logic [TIME_W-1:0] elapsed;
    logic              started;
    logic              enable;
  } state_t;

  function automatic logic [1:0] phase_code(input phase_e ph);
    logic [1:0] code;
    unique case (ph)
      PH_UP:      code = PCODE_UP;
      PH_HOLD_HI: code = PCODE_HOLD_HI;
      PH_DOWN:    code = PCODE_DOWN;
      PH_HOLD_LO: code = PCODE_HOLD_LO;
      default:    code = PCODE_UP;
    endcase
    return code;
  endfunction

endpackage

// File: hw/rtl/timed_ramp_hold_profile.sv
// ----------------------------------------------------------------------------
// timed_ramp_hold_profile
// Trapezoidal position set-point sequencer: ramp up, hold high, ramp down,
// hold low, then repeat.
// ----------------------------------------------------------------------------
// The input channel carries either a time tick (cmd_i low, delta_ms_i gives
// the elapsed milliseconds) or a panel word (cmd_i high); a panel word with
// bit 4 clear latches start, and ticks before start change nothing.
// Every input transaction yields exactly one output transaction that shows
// the goal position, phase, driver enable and running flag after it.
// An input transaction is captured in an input register, the next state is
// formed combinationally from it, and the result lands in an output register.
// Throughput is one transaction per cycle when the receiver does not stall.
// A stalled result holds in the output register while one more transaction
// waits in the input register; in_stall_o rises only when both are full.
// Configuration writes take effect at once; the user makes them only while
// idle, and the block does not enforce this. Reset clears the profile state,
// loads the default timing registers and empties both pipeline registers.
// ----------------------------------------------------------------------------
`include "timed_ramp_hold_profile_assert.svh"

module timed_ramp_hold_profile #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [7:0]  delta_ms_i,
  input  logic [15:0] panel_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [25:0] goal_position_o,
  output logic [1:0]  phase_now_o,
  output logic        enable_out_o,
  output logic        running_out_o
);
  import trhp_pkg::*;

  localparam int unsigned ACC_W = POS_W + FRAC_BITS;

  cfg_t                 cfg_q;
  state_t               state_q, state_d;
  logic [ACC_W-1:0]     goal_q, goal_d;
  logic [ACC_W+GOAL_W-1:0] goal_wide;

  logic                 in_valid_q;
  logic                 cmd_q;
  logic [DELTA_W-1:0]   delta_q;
  logic [PANEL_W-1:0]   panel_q;

  logic                 out_valid_q;
  logic [GOAL_W-1:0]    out_goal_q;
  logic [1:0]           out_phase_q;
  logic                 out_enable_q;
  logic                 out_running_q;

  logic                 in_accept;
  logic                 advance;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_pos   <= MAX_POS_RST;
      cfg_q.up_step   <= UP_STEP_RST;
      cfg_q.down_step <= DOWN_STEP_RST;
      cfg_q.up_time   <= UP_TIME_RST;
      cfg_q.hi_time   <= HI_TIME_RST;
      cfg_q.down_time <= DOWN_TIME_RST;
      cfg_q.lo_time   <= LO_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MAX_POS:   cfg_q.max_pos   <= cfg_data_i[POS_W-1:0];
        CFG_UP_STEP:   cfg_q.up_step   <= cfg_data_i[STEP_W-1:0];
        CFG_DOWN_STEP: cfg_q.down_step <= cfg_data_i[STEP_W-1:0];
        CFG_UP_TIME:   cfg_q.up_time   <= cfg_data_i[TIME_W-1:0];
        CFG_HI_TIME:   cfg_q.hi_time   <= cfg_data_i[TIME_W-1:0];
        CFG_DOWN_TIME: cfg_q.down_time <= cfg_data_i[TIME_W-1:0];
        CFG_LO_TIME:   cfg_q.lo_time   <= cfg_data_i[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q   <= cmd_i;
      delta_q <= delta_ms_i;
      panel_q <= panel_word_i;
    end
  end

  trhp_step #(
    .FRAC_BITS (FRAC_BITS)
  ) u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .goal_i       (goal_q),
    .cmd_i        (cmd_q),
    .delta_ms_i   (delta_q),
    .panel_word_i (panel_q),
    .state_o      (state_d),
    .goal_o       (goal_d)
  );

  assign goal_wide = {{GOAL_W{1'b0}}, goal_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase   <= PH_UP;
      state_q.elapsed <= '0;
      state_q.started <= 1'b0;
      state_q.enable  <= 1'b0;
      goal_q          <= '0;
    end else if (in_valid_q && advance) begin
      state_q <= state_d;
      goal_q  <= goal_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_valid_q && advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_q && advance) begin
      out_goal_q    <= goal_wide[GOAL_W-1:0];
      out_phase_q   <= phase_code(state_d.phase);
      out_enable_q  <= state_d.enable;
      out_running_q <= state_d.started;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign goal_position_o = out_goal_q;
  assign phase_now_o     = out_phase_q;
  assign enable_out_o    = out_enable_q;
  assign running_out_o   = out_running_q;

  `TRHP_ASSERT_NEXT(a_start_sticky, state_q.started, state_q.started, "start latch was cleared")
  `TRHP_ASSERT_SAME(a_enable_needs_start, state_q.enable, state_q.started, "driver enabled before start")
  `TRHP_ASSERT_NEXT(a_result_loaded, in_valid_q && advance, out_valid_q, "advanced transaction produced no result")
  `TRHP_ASSERT_SAME(a_hold_low_zero, out_valid_q && (out_phase_q == PCODE_HOLD_LO) && !out_enable_q, out_goal_q == '0, "goal not zero in hold low")

endmodule

// File: hw/rtl/trhp_step.sv
// ----------------------------------------------------------------------------
// trhp_step
// Next-state logic for one transaction: phase timing, goal ramp and start latch.
// ----------------------------------------------------------------------------
module trhp_step #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  trhp_pkg::cfg_t                        cfg_i,
  input  trhp_pkg::state_t                      state_i,
  input  logic [trhp_pkg::POS_W+FRAC_BITS-1:0]  goal_i,
  input  logic                                  cmd_i,
  input  logic [trhp_pkg::DELTA_W-1:0]          delta_ms_i,
  input  logic [trhp_pkg::PANEL_W-1:0]          panel_word_i,
  output trhp_pkg::state_t                      state_o,
  output logic [trhp_pkg::POS_W+FRAC_BITS-1:0]  goal_o
);
  import trhp_pkg::*;

  localparam int unsigned ACC_W  = POS_W + FRAC_BITS;
  localparam int unsigned PROD_W = STEP_W + DELTA_W;
  localparam int unsigned SUM_W  = ACC_W + STEP_W;

  logic [PROD_W-1:0]  up_prod;
  logic [PROD_W-1:0]  down_prod;
  logic [SUM_W-1:0]   goal_ext;
  logic [SUM_W-1:0]   top_ext;
  logic [SUM_W-1:0]   up_sum;
  logic [SUM_W-1:0]   down_ext;
  logic [SUM_W-1:0]   down_diff;
  logic [ACC_W-1:0]   top;
  logic [ACC_W-1:0]   up_goal;
  logic [ACC_W-1:0]   down_goal;
  logic [TIME_W:0]    elapsed_sum;
  logic [TIME_W-1:0]  elapsed_sat;

  assign up_prod   = {{DELTA_W{1'b0}}, cfg_i.up_step} * {{STEP_W{1'b0}}, delta_ms_i};
  assign down_prod = {{DELTA_W{1'b0}}, cfg_i.down_step} * {{STEP_W{1'b0}}, delta_ms_i};

  assign top      = {cfg_i.max_pos, {FRAC_BITS{1'b0}}};
  assign goal_ext = {{STEP_W{1'b0}}, goal_i};
  assign top_ext  = {{STEP_W{1'b0}}, top};
  assign up_sum   = goal_ext + {{(SUM_W-PROD_W){1'b0}}, up_prod};
  assign up_goal  = (up_sum > top_ext) ? top : up_sum[ACC_W-1:0];

  assign down_ext  = {{(SUM_W-PROD_W){1'b0}}, down_prod};
  assign down_diff = goal_ext - down_ext;
  assign down_goal = (down_ext >= goal_ext) ? '0 : down_diff[ACC_W-1:0];

  assign elapsed_sum = {1'b0, state_i.elapsed} + {{(TIME_W+1-DELTA_W){1'b0}}, delta_ms_i};
  assign elapsed_sat = elapsed_sum[TIME_W] ? {TIME_W{1'b1}} : elapsed_sum[TIME_W-1:0];

  always_comb begin
    state_o = state_i;
    goal_o  = goal_i;
    if (cmd_i) begin
      if (!panel_word_i[START_BIT]) begin
        state_o.started = 1'b1;
      end
    end else if (state_i.started) begin
      state_o.elapsed = elapsed_sat;
      unique case (state_i.phase)
        PH_UP: begin
          state_o.enable = 1'b1;
          goal_o = up_goal;
          if (elapsed_sat >= cfg_i.up_time) begin
            goal_o          = top;
            state_o.phase   = PH_HOLD_HI;
            state_o.elapsed = '0;
          end
        end
        PH_HOLD_HI: begin
          goal_o = top;
          if (elapsed_sat >= cfg_i.hi_time) begin
            state_o.phase   = PH_DOWN;
            state_o.elapsed = '0;
          end
        end
        PH_DOWN: begin
          goal_o = down_goal;
          if (elapsed_sat >= cfg_i.down_time) begin
            goal_o          = '0;
            state_o.phase   = PH_HOLD_LO;
            state_o.elapsed = '0;
          end
        end
        PH_HOLD_LO: begin
          goal_o         = '0;
          state_o.enable = 1'b0;
          if (elapsed_sat >= cfg_i.lo_time) begin
            state_o.phase   = PH_UP;
            state_o.elapsed = '0;
          end
        end
        default: begin
          state_o = state_i;
        end
      endcase
    end
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// Testbench for timed_ramp_hold_profile
// Drives time ticks and panel words into the set-point sequencer and follows
// the ramp, hold and restart behavior with its own copy of the profile state.
// Every result transaction is compared field by field with the oldest
// predicted set-point. Register settings change between runs, from all zeros
// to the largest values, while the sender and receiver idle and stall at
// several rates.
// ----------------------------------------------------------------------------
import trhp_pkg::*;

typedef struct {
  logic [GOAL_W-1:0] goal;
  logic [1:0]        phase;
  logic              enable;
  logic              running;
} setpoint_t;

class setpoint_board;
  localparam int unsigned FRAC = 16;

  logic [POS_W-1:0]  max_pos;
  logic [STEP_W-1:0] up_step;
  logic [STEP_W-1:0] down_step;
  logic [TIME_W-1:0] up_time;
  logic [TIME_W-1:0] hi_time;
  logic [TIME_W-1:0] down_time;
  logic [TIME_W-1:0] lo_time;

  longint unsigned goal;
  logic [1:0]      phase;
  int unsigned     elapsed;
  bit              started;
  bit              enable;

  setpoint_t due_setpoints[$];
  int        errors;

  function new();
    max_pos   = MAX_POS_RST;
    up_step   = UP_STEP_RST;
    down_step = DOWN_STEP_RST;
    up_time   = UP_TIME_RST;
    hi_time   = HI_TIME_RST;
    down_time = DOWN_TIME_RST;
    lo_time   = LO_TIME_RST;
    goal      = 0;
    phase     = PCODE_UP;
    elapsed   = 0;
    started   = 0;
    enable    = 0;
    errors    = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_MAX_POS:   max_pos   = val[POS_W-1:0];
      CFG_UP_STEP:   up_step   = val[STEP_W-1:0];
      CFG_DOWN_STEP: down_step = val[STEP_W-1:0];
      CFG_UP_TIME:   up_time   = val[TIME_W-1:0];
      CFG_HI_TIME:   hi_time   = val[TIME_W-1:0];
      CFG_DOWN_TIME: down_time = val[TIME_W-1:0];
      CFG_LO_TIME:   lo_time   = val[TIME_W-1:0];
      default: begin
      end
    endcase
  endfunction

  function int pending();
    return due_setpoints.size();
  endfunction

  function void advance_time(logic [DELTA_W-1:0] delta);
    longint unsigned top;
    longint unsigned dec;
    top = longint'(max_pos) << FRAC;
    elapsed = elapsed + delta;
    if (elapsed > 16'hFFFF) elapsed = 16'hFFFF;
    case (phase)
      PCODE_UP: begin
        enable = 1;
        goal = goal + longint'(up_step) * longint'(delta);
        if (goal > top) goal = top;
        if (elapsed >= up_time) begin
          goal = top;
          phase = PCODE_HOLD_HI;
          elapsed = 0;
        end
      end
      PCODE_HOLD_HI: begin
        goal = top;
        if (elapsed >= hi_time) begin
          phase = PCODE_DOWN;
          elapsed = 0;
        end
      end
      PCODE_DOWN: begin
        dec = longint'(down_step) * longint'(delta);
        goal = (dec >= goal) ? 0 : goal - dec;
        if (elapsed >= down_time) begin
          goal = 0;
          phase = PCODE_HOLD_LO;
          elapsed = 0;
        end
      end
      default: begin
        goal = 0;
        enable = 0;
        if (elapsed >= lo_time) begin
          phase = PCODE_UP;
          elapsed = 0;
        end
      end
    endcase
  endfunction

  function void note_input(logic cmd, logic [DELTA_W-1:0] delta,
                           logic [PANEL_W-1:0] panel);
    setpoint_t sp;
    if (!cmd) begin
      if (started) advance_time(delta);
    end else if (!panel[START_BIT]) begin
      started = 1;
    end
    sp.goal    = goal[GOAL_W-1:0];
    sp.phase   = phase;
    sp.enable  = enable;
    sp.running = started;
    due_setpoints.push_back(sp);
  endfunction

  function void check_result(logic [GOAL_W-1:0] goal_o, logic [1:0] phase_o,
                             logic enable_o, logic running_o);
    setpoint_t sp;
    if (due_setpoints.size() == 0) begin
      $display("%0t: unexpected result, goal %h phase %0d", $time, goal_o, phase_o);
      errors++;
      return;
    end
    sp = due_setpoints.pop_front();
    if (goal_o !== sp.goal) begin
      $display("%0t: goal_position expected %h actual %h", $time, sp.goal, goal_o);
      errors++;
    end
    if (phase_o !== sp.phase) begin
      $display("%0t: phase_now expected %0d actual %0d", $time, sp.phase, phase_o);
      errors++;
    end
    if (enable_o !== sp.enable) begin
      $display("%0t: enable_out expected %0b actual %0b", $time, sp.enable, enable_o);
      errors++;
    end
    if (running_o !== sp.running) begin
      $display("%0t: running_out expected %0b actual %0b", $time, sp.running, running_o);
      errors++;
    end
  endfunction
endclass

module tb;
  localparam int unsigned FRAC           = 16;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [2:0]  CFG_UNUSED     = 3'd7;

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                cfg_we_i     = 1'b0;
  logic [2:0]          cfg_index_i  = '0;
  logic [CFG_W-1:0]    cfg_data_i   = '0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic                cmd_i        = 1'b0;
  logic [DELTA_W-1:0]  delta_ms_i   = '0;
  logic [PANEL_W-1:0]  panel_word_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [GOAL_W-1:0]   goal_position_o;
  logic [1:0]          phase_now_o;
  logic                enable_out_o;
  logic                running_out_o;

  setpoint_board sb;
  int sender_idle = 0;
  int recv_stall  = 0;
  int quiet_cycles = 0;

  timed_ramp_hold_profile #(
    .FRAC_BITS(FRAC)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .delta_ms_i     (delta_ms_i),
    .panel_word_i   (panel_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .goal_position_o(goal_position_o),
    .phase_now_o    (phase_now_o),
    .enable_out_o   (enable_out_o),
    .running_out_o  (running_out_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < recv_stall);
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(goal_position_o, phase_now_o, enable_out_o, running_out_o);
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timed_ramp_hold_profile verification failed");
        $finish;
      end
    end
  end

  task automatic send(logic cmd, logic [DELTA_W-1:0] delta, logic [PANEL_W-1:0] panel);
    while ($urandom_range(0, 99) < sender_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= cmd;
    delta_ms_i   <= delta;
    panel_word_i <= panel;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(cmd, delta, panel);
  endtask

  task automatic tick(logic [DELTA_W-1:0] delta);
    send(1'b0, delta, 16'($urandom));
  endtask

  task automatic panel(logic [PANEL_W-1:0] word);
    send(1'b1, 8'($urandom), word);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  task automatic program_profile(logic [CFG_W-1:0] pos, logic [CFG_W-1:0] up,
                                 logic [CFG_W-1:0] down, logic [CFG_W-1:0] t_up,
                                 logic [CFG_W-1:0] t_hi, logic [CFG_W-1:0] t_down,
                                 logic [CFG_W-1:0] t_lo);
    write_reg(CFG_MAX_POS, pos);
    write_reg(CFG_UP_STEP, up);
    write_reg(CFG_DOWN_STEP, down);
    write_reg(CFG_UP_TIME, t_up);
    write_reg(CFG_HI_TIME, t_hi);
    write_reg(CFG_DOWN_TIME, t_down);
    write_reg(CFG_LO_TIME, t_lo);
    write_reg(CFG_UNUSED, 20'($urandom));
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_W-1:0] rand_duration();
    if ($urandom_range(0, 7) == 0) return {4'($urandom), 16'd0};
    return {4'($urandom), 16'($urandom_range(0, 3000))};
  endfunction

  function automatic logic [CFG_W-1:0] rand_step();
    return 20'($urandom) >> $urandom_range(0, 19);
  endfunction

  initial begin
    int n_items;
    logic [DELTA_W-1:0] delta;

    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: ticks before and after start, panel words that start or not.
    tick(8'd255);
    panel(16'hFFFF);
    tick(8'd0);
    panel(16'h0010);
    panel(16'hFFEF);
    panel(16'h0000);
    tick(8'd255);
    tick(8'd0);

    // Short phases with a steep clamped ramp and a slow descent.
    drain();
    program_profile(20'hFFFFF, 20'hFFFFF, 20'd1, 20'd600, 20'd3, 20'd10, 20'd0);
    tick(8'd255);
    tick(8'd255);
    tick(8'd0);
    tick(8'd3);
    tick(8'd4);
    tick(8'd255);
    tick(8'd0);
    tick(8'd0);

    // Zero durations end each phase on the first tick, even with no time.
    drain();
    program_profile(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
    repeat (5) tick(8'd0);

    for (int blk = 0; blk < 8; blk++) begin
      drain();
      case (blk / 2)
        0: begin sender_idle = 0;  recv_stall = 0;  end
        1: begin sender_idle = 69; recv_stall = 0;  end
        2: begin sender_idle = 0;  recv_stall = 69; end
        default: begin sender_idle = 33; recv_stall = 33; end
      endcase
      case (blk)
        0: program_profile(20'h003FF, 20'hFFFFF, 20'hFFFFF, 20'h00000,
                           20'h0FFFF, 20'h0FFFF, 20'h00000);
        5: program_profile(20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0, 20'd0);
        default: program_profile(20'($urandom), rand_step(), rand_step(),
                                 rand_duration(), rand_duration(),
                                 rand_duration(), rand_duration());
      endcase
      n_items = (blk == 0) ? 400 : 150;
      repeat (n_items) begin
        if ($urandom_range(0, 59) == 0) drain();
        if ($urandom_range(0, 9) == 0) begin
          panel(16'($urandom));
        end else begin
          if (blk == 0) delta = 8'($urandom_range(180, 255));
          else if ($urandom_range(0, 3) == 0) delta = 8'($urandom_range(0, 7));
          else delta = 8'($urandom);
          tick(delta);
        end
      end
    end

    drain();
    recv_stall = 0;
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("timed_ramp_hold_profile verification clean");
    end else begin
      $display("timed_ramp_hold_profile verification failed");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/trhp_pkg.sv
hw/rtl/trhp_step.sv
hw/rtl/timed_ramp_hold_profile.sv
test/tb.sv
